// ----- src/kcs_pkg.sv -----
// Package for the keyframe camera sampler: sizes, constants, the sequencer
// state type and the channel-to-slot function. No dependencies.
`default_nettype none
package kcs_pkg;
   localparam int MAX_FRAMES_DEF = 1024;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int SLOTS          = 6;
   localparam logic [31:0] RAD_PER_DEG_Q32 = 32'd74961321;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_MOD   = 11'b00000000010,
      ST_RDA   = 11'b00000000100,
      ST_RDB   = 11'b00000001000,
      ST_MUL   = 11'b00000010000,
      ST_SQ    = 11'b00000100000,
      ST_SQRT  = 11'b00001000000,
      ST_DIV   = 11'b00010000000,
      ST_FOV   = 11'b00100000000,
      ST_DONE  = 11'b01000000000,
      ST_ZERO  = 11'b10000000000
   } state_type;

   function automatic logic [2:0] slot_of(input logic [4:0] ch);
      logic [2:0] s;
      s = 3'd7;
      case (ch)
         5'd2:    s = 3'd0;
         5'd3:    s = 3'd1;
         5'd6:    s = 3'd2;
         5'd7:    s = 3'd3;
         5'd10:   s = 3'd4;
         5'd11:   s = 3'd5;
         default: s = 3'd7;
      endcase
      return s;
   endfunction
endpackage
`default_nettype wire

// ----- src/keyframe_camera_sampler.sv -----
// Top level of the keyframe camera sampler: table stores, sequencer and
// shared multiplier/square root. Uses kcs_pkg and kcs_divider.
// Loads are taken only while idle. A sample holds busy through a modulo divide, the blend,
// the square, the square root, three unit divides and a finish step, and a new sample is
// taken only once busy is low; an empty track or a degenerate forward ends it early. The
// result beat is the cycle in which busy falls; receiver cannot stall. Reset clears frame_count and sequencer.
`default_nettype none
module keyframe_camera_sampler #(
   parameter int MAX_FRAMES = kcs_pkg::MAX_FRAMES_DEF,
   parameter int FRAC_BITS  = kcs_pkg::FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_func,
   input  wire logic [9:0]         req_frame_index,
   input  wire logic [4:0]         req_channel,
   input  wire logic signed [31:0] req_word_value,
   input  wire logic signed [31:0] req_sample_time,
   input  wire logic               csr_we,
   input  wire logic [10:0]        csr_wdata,
   output logic                    rsp_valid,
   output logic                    rsp_ok,
   output logic signed [31:0]      rsp_eye_x,
   output logic signed [31:0]      rsp_eye_y,
   output logic signed [31:0]      rsp_eye_z,
   output logic signed [31:0]      rsp_target_x,
   output logic signed [31:0]      rsp_target_y,
   output logic signed [31:0]      rsp_target_z,
   output logic [18:0]             rsp_fov_radians
);
   localparam int AW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int MW  = $clog2(MAX_FRAMES * kcs_pkg::SLOTS);
   localparam int FW  = $clog2(MAX_FRAMES + 1);
   localparam logic [63:0] ONE_Q    = 64'd1 << FRAC_BITS;
   localparam logic [63:0] FOV_DEF  = (64'd3785 * (64'd1 << FRAC_BITS) + 64'd50) / 64'd100;
   localparam logic [63:0] DEG_LO   = 64'd1 << FRAC_BITS;
   localparam logic [63:0] DEG_HI   = 64'd179 << FRAC_BITS;

   logic signed [31:0] mat_mem [MAX_FRAMES*kcs_pkg::SLOTS];
   logic signed [31:0] fov_mem [MAX_FRAMES];
   logic signed [31:0] mat_q, fov_q;
   logic [MW-1:0]      mat_addr;

   kcs_pkg::state_type st_ff, st_in;
   logic [10:0]        fc_ff;
   logic [FW-1:0]      fc_eff;
   logic [31:0]        t_ff, t_in;
   logic [AW-1:0]      f0_ff, f0_in, f1_ff, f1_in;
   logic [FRAC_BITS-1:0] w_ff, w_in;
   logic [2:0]         slot_ff, slot_in;
   logic signed [31:0] a_ff, a_in;
   logic signed [31:0] v_ff [kcs_pkg::SLOTS];
   logic signed [31:0] v_new;
   logic [65:0]        sq_ff, sq_in;
   logic [65:0]        sx_ff, sx_in;
   logic [32:0]        sr_ff, sr_in;
   logic [5:0]         k_ff, k_in;
   logic [1:0]         dv_ff, dv_in;
   logic signed [31:0] tg_ff [3];
   logic               wait_ff, wait_in;
   logic               vld_ff, ok_ff;
   logic signed [33:0] mul_a;
   logic signed [33:0] mul_b;
   logic signed [67:0] mul_p;
   logic               dgo;
   logic [63:0]        dnum;
   logic [47:0]        dden;
   logic               ddone;
   logic [63:0]        dquo;
   logic [47:0]        drem;
   logic signed [32:0] fwd_c;
   logic signed [31:0] eye_c;
   logic [63:0]        fmag;
   logic signed [34:0] tsum;
   logic signed [63:0] uq;
   logic signed [32:0] eyey;
   logic [63:0]        fovr;
   logic [31:0]        degv;

   assign fc_eff = (32'(fc_ff) > MAX_FRAMES) ? FW'(MAX_FRAMES) : FW'(fc_ff);
   assign busy = (st_ff != kcs_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (start && !busy && !req_func && ({22'd0, req_frame_index} < MAX_FRAMES)) begin
         if (kcs_pkg::slot_of(req_channel) != 3'd7)
            mat_mem[MW'(req_frame_index) * MW'(kcs_pkg::SLOTS)
                    + MW'(kcs_pkg::slot_of(req_channel))] <= req_word_value;
         else if (req_channel == 5'd16)
            fov_mem[req_frame_index[AW-1:0]] <= req_word_value;
      end
      mat_q <= mat_mem[mat_addr];
      fov_q <= fov_mem[f0_ff];
   end

   assign mat_addr = MW'((st_ff == kcs_pkg::ST_RDA ? f0_ff : f1_ff)) * MW'(kcs_pkg::SLOTS)
                     + MW'(slot_ff);

   kcs_divider #(.NW(64), .DW(48)) u_div (
      .clock(clock), .reset(reset), .go(dgo), .num(dnum), .den(dden),
      .done(ddone), .quo(dquo), .rem(drem)
   );

   always_comb begin
      case (dv_ff)
         2'd0:    fwd_c = -33'(v_ff[0]);
         2'd1:    fwd_c = 33'(v_ff[2]);
         default: fwd_c = -33'(v_ff[4]);
      endcase
      case (dv_ff)
         2'd0:    eye_c = v_ff[1];
         2'd1:    eye_c = 32'(eyey);
         default: eye_c = v_ff[5];
      endcase
   end

   assign eyey = (v_ff[3] == 32'sh80000000) ? 33'sh07fffffff : -33'(v_ff[3]);
   assign fmag = fwd_c[32] ? 64'(-fwd_c) : 64'(fwd_c);
   assign mul_a = (st_ff == kcs_pkg::ST_SQ) ? 34'(signed'({1'b0, fmag[32:0]}))
                                           : 34'(signed'(mat_q) - signed'(a_ff));
   assign mul_b = (st_ff == kcs_pkg::ST_SQ) ? 34'(signed'({1'b0, fmag[32:0]}))
                                           : 34'(signed'({1'b0, w_ff}));
   assign mul_p = mul_a * mul_b;
   assign v_new = 32'(a_ff + 32'(mul_p >>> FRAC_BITS));
   assign uq = fwd_c[32] ? -64'(dquo) : 64'(dquo);
   assign tsum = 35'(eye_c) + 35'(uq);
   assign degv = ((fov_q <= $signed(DEG_LO[31:0])) || (fov_q >= $signed(DEG_HI[31:0])))
                 ? FOV_DEF[31:0] : fov_q;
   assign fovr = (64'(degv) * 64'(kcs_pkg::RAD_PER_DEG_Q32) + 64'h80000000) >> 32;

   always_comb begin
      st_in = st_ff; t_in = t_ff; f0_in = f0_ff; f1_in = f1_ff; w_in = w_ff;
      slot_in = slot_ff; a_in = a_ff; sq_in = sq_ff; sx_in = sx_ff;
      sr_in = sr_ff; k_in = k_ff; dv_in = dv_ff; wait_in = 1'b0;
      dgo = 1'b0; dnum = '0; dden = '0;
      unique case (st_ff)
         kcs_pkg::ST_IDLE: begin
            if (start && req_func) begin
               t_in = req_sample_time[31] ? 32'd0 : req_sample_time;
               st_in = (fc_eff == '0) ? kcs_pkg::ST_ZERO : kcs_pkg::ST_MOD;
               wait_in = 1'b1;
            end
         end
         kcs_pkg::ST_MOD: begin
            if (wait_ff) begin
               dgo = 1'b1; dnum = 64'(t_ff) * 64'd30;
               dden = 48'(fc_eff) << FRAC_BITS;
            end else if (ddone) begin
               f0_in = AW'(drem >> FRAC_BITS);
               w_in = drem[FRAC_BITS-1:0];
               f1_in = ((48'(drem >> FRAC_BITS) + 48'd1) >= 48'(fc_eff)) ? '0
                       : AW'((drem >> FRAC_BITS) + 48'd1);
               slot_in = '0; st_in = kcs_pkg::ST_RDA;
            end
         end
         kcs_pkg::ST_RDA: st_in = kcs_pkg::ST_RDB;
         kcs_pkg::ST_RDB: begin
            a_in = mat_q; st_in = kcs_pkg::ST_MUL;
         end
         kcs_pkg::ST_MUL: begin
            if (slot_ff == 3'(kcs_pkg::SLOTS - 1)) begin
               st_in = kcs_pkg::ST_SQ; dv_in = '0; sq_in = '0;
            end else begin
               slot_in = slot_ff + 3'd1; st_in = kcs_pkg::ST_RDA;
            end
         end
         kcs_pkg::ST_SQ: begin
            sq_in = sq_ff + 66'(mul_p);
            if (dv_ff == 2'd2) begin
               st_in = kcs_pkg::ST_SQRT; sx_in = sq_ff + 66'(mul_p);
               sr_in = '0; k_in = 6'd32;
            end else dv_in = dv_ff + 2'd1;
         end
         kcs_pkg::ST_SQRT: begin
            if (sx_ff >= (66'(sr_ff) << k_ff) + (66'd1 << (2 * (k_ff - 6'd1)))) begin
               sx_in = sx_ff - ((66'(sr_ff) << k_ff) + (66'd1 << (2 * (k_ff - 6'd1))));
               sr_in = sr_ff | (33'd1 << (k_ff - 6'd1));
            end
            k_in = k_ff - 6'd1;
            if (k_ff == 6'd1) begin
               st_in = kcs_pkg::ST_DIV; dv_in = '0; wait_in = 1'b1;
            end
         end
         kcs_pkg::ST_DIV: begin
            if (wait_ff) begin
               if (64'(sr_ff) * 64'd1000000 < ONE_Q) st_in = kcs_pkg::ST_ZERO;
               else begin
                  dgo = 1'b1; dnum = fmag << FRAC_BITS; dden = 48'(sr_ff);
               end
            end else if (ddone) begin
               if (dv_ff == 2'd2) st_in = kcs_pkg::ST_FOV;
               else begin
                  dv_in = dv_ff + 2'd1; wait_in = 1'b1;
               end
            end
         end
         kcs_pkg::ST_FOV:  st_in = kcs_pkg::ST_DONE;
         kcs_pkg::ST_DONE: st_in = kcs_pkg::ST_IDLE;
         kcs_pkg::ST_ZERO: st_in = kcs_pkg::ST_IDLE;
         default:          st_in = kcs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      t_ff <= t_in; f0_ff <= f0_in; f1_ff <= f1_in; w_ff <= w_in; slot_ff <= slot_in;
      a_ff <= a_in; sq_ff <= sq_in; sx_ff <= sx_in; sr_ff <= sr_in;
      k_ff <= k_in; dv_ff <= dv_in;
      if (st_ff == kcs_pkg::ST_MUL) v_ff[slot_ff] <= v_new;
      if (st_ff == kcs_pkg::ST_DIV && ddone && !wait_ff)
         tg_ff[dv_ff] <= (tsum > 35'sh07fffffff) ? 32'sh7fffffff :
                         (tsum < -35'sh080000000) ? 32'sh80000000 : 32'(tsum);
      if (st_ff == kcs_pkg::ST_DONE) begin
         rsp_eye_x <= v_ff[1]; rsp_eye_y <= 32'(eyey); rsp_eye_z <= v_ff[5];
         rsp_target_x <= tg_ff[0]; rsp_target_y <= tg_ff[1]; rsp_target_z <= tg_ff[2];
         rsp_fov_radians <= fovr[18:0];
      end else begin
         rsp_eye_x <= '0; rsp_eye_y <= '0; rsp_eye_z <= '0; rsp_target_x <= '0;
         rsp_target_y <= '0; rsp_target_z <= '0; rsp_fov_radians <= '0;
      end
      if (reset) begin
         st_ff <= kcs_pkg::ST_IDLE; fc_ff <= '0; wait_ff <= 1'b0;
         vld_ff <= 1'b0; ok_ff <= 1'b0;
      end else begin
         st_ff <= st_in; wait_ff <= wait_in;
         if (csr_we) fc_ff <= csr_wdata;
         vld_ff <= (st_ff == kcs_pkg::ST_DONE) || (st_ff == kcs_pkg::ST_ZERO);
         ok_ff <= (st_ff == kcs_pkg::ST_DONE);
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_ok = ok_ff;
endmodule
`default_nettype wire

// ----- src/kcs_divider.sv -----
// Restoring divider, one quotient bit per cycle, for the modulo and the
// unit-vector divides. Depends on nothing.
`default_nettype none
module kcs_divider #(
   parameter int NW = 64,
   parameter int DW = 48
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          go,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               done,
   output logic [NW-1:0]      quo,
   output logic [DW-1:0]      rem
);
   localparam int CW = $clog2(NW + 1);
   logic [NW-1:0] q_ff, q_in;
   logic [DW-1:0] r_ff, r_in, d_ff, d_in;
   logic [CW-1:0] n_ff, n_in;
   logic          run_ff, run_in, done_ff, done_in;
   logic [DW:0]   trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; n_in = n_ff;
      run_in = run_ff; done_in = 1'b0;
      trial = {r_ff, q_ff[NW-1]};
      if (go) begin
         q_in = num; r_in = '0; d_in = den; n_in = CW'(NW); run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = DW'(trial - {1'b0, d_ff});
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = trial[DW-1:0];
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         n_in = n_ff - 1'b1;
         if (n_ff == CW'(1)) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; n_ff <= n_in;
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;
   assign rem  = r_ff;
endmodule
`default_nettype wire
